/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define QPMT_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check that a condition never holds outside reset.
`define QPMT_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `QPMT_ASSERT_CLK(lbl, clk, rst, !(cond), msg)

`endif

/* rtl/qpmt_pkg.sv */
`timescale 1ns / 1ps
package qpmt_pkg;

   localparam int PLANES_DEFAULT = 8;
   localparam int QUADRANTS      = 4;
   localparam int MASK_W         = 8;
   localparam int THRESH_W       = 4;
   localparam int PAIR_W         = 3;
   localparam int COUNT_W        = 3;
   localparam int PANEL_W        = 3;
   localparam int PLANE_W        = 4;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 8;

   // item commands
   localparam logic CMD_HIT  = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DEEP_MASK      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SHALLOW_MASK   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEEP_THRESH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SHALLOW_THRESH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DEEP_PAIR      = 3'd4;

   // register reset values
   localparam logic [MASK_W-1:0]   DEEP_MASK_RST      = 8'd255;
   localparam logic [MASK_W-1:0]   SHALLOW_MASK_RST   = 8'd63;
   localparam logic [THRESH_W-1:0] DEEP_THRESH_RST    = 4'd7;
   localparam logic [THRESH_W-1:0] SHALLOW_THRESH_RST = 4'd5;
   localparam logic [PAIR_W-1:0]   DEEP_PAIR_RST      = 3'd2;

   typedef struct packed {
      logic               command;
      logic [PANEL_W-1:0] panel;
      logic [PLANE_W-1:0] plane;
   } item_type;

   // Quadrants fed by a panel; small panels 1 and 4 feed two.
   function automatic logic [QUADRANTS-1:0] panel_quadrants(input logic [PANEL_W-1:0] panel);
      logic [QUADRANTS-1:0] q;
      q[0] = panel inside {3'd0, 3'd1};
      q[1] = panel inside {3'd1, 3'd2};
      q[2] = panel inside {3'd3, 3'd4};
      q[3] = panel inside {3'd4, 3'd5};
      return q;
   endfunction

   function automatic logic [THRESH_W-1:0] count_ones(input logic [MASK_W-1:0] v);
      logic [THRESH_W-1:0] n;
      n = '0;
      for (int i = 0; i < MASK_W; i++) begin
         n = n + THRESH_W'(v[i]);
      end
      return n;
   endfunction

endpackage

/* rtl/qpmt_if.sv */
`timescale 1ns / 1ps
interface qpmt_req_if
   import qpmt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               command;
   logic [PANEL_W-1:0] panel;
   logic [PLANE_W-1:0] plane;

   modport source (output valid, command, panel, plane, input ready);
   modport sink   (input valid, command, panel, plane, output ready);
endinterface

interface qpmt_rsp_if
   import qpmt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               deep_deep;
   logic               deep_shallow;
   logic [COUNT_W-1:0] deep_count;
   logic [COUNT_W-1:0] shallow_count;

   modport source (output valid, deep_deep, deep_shallow, deep_count, shallow_count,
                   input ready);
   modport sink   (input valid, deep_deep, deep_shallow, deep_count, shallow_count,
                   output ready);
endinterface

interface qpmt_csr_if
   import qpmt_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/quadrant_plane_majority_trigger_unit.sv */
// Quadrant plane-majority trigger. Hit items (panel, plane) set the plane bit in
// each quadrant the panel feeds; planes at or above PLANES and panels 6 and 7
// are dropped. An end-of-event item counts, per quadrant, the set planes under
// the deep and shallow masks, compares them with the thresholds, returns one
// result item (deep_deep, deep_shallow and both quadrant counts) and clears the
// plane store. The block takes an item on every clock while the input register
// can advance; each item is held in the input register, where the store update
// or the evaluation runs. A result item is loaded into the output register at
// the edge where its end-of-event item leaves the input register, so it passes
// through the input register and then the output register. Hits keep flowing
// while a result waits; an end-of-event item holds in the input register, and
// holds back the items behind it, while the previous result is not yet taken.
// The user must write registers through the csr channel only while the block
// holds no unfinished item; the block does not enforce this. Writes never stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quadrant_plane_majority_trigger_unit
   import qpmt_pkg::*;
#(
   parameter int PLANES = PLANES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   qpmt_req_if.sink   req_ch,
   qpmt_rsp_if.source rsp_ch,
   qpmt_csr_if.sink   csr_ch
);

   // Store wide enough to reach every mask bit, zero above PLANES.
   localparam int EXT_W = (PLANES > MASK_W) ? PLANES : MASK_W;
   localparam logic [PLANE_W:0] PLANE_LIMIT = (PLANE_W + 1)'(PLANES);

   // configuration registers
   logic [MASK_W-1:0]   deep_mask_ff,      deep_mask_in;
   logic [MASK_W-1:0]   shallow_mask_ff,   shallow_mask_in;
   logic [THRESH_W-1:0] deep_thresh_ff,    deep_thresh_in;
   logic [THRESH_W-1:0] shallow_thresh_ff, shallow_thresh_in;
   logic [PAIR_W-1:0]   deep_pair_ff,      deep_pair_in;

   // input register
   logic     stage_valid_ff, stage_valid_in;
   item_type stage_item_ff,  stage_item_in;

   // plane store, one row per quadrant
   logic [PLANES-1:0] store_ff [QUADRANTS];
   logic [PLANES-1:0] store_in [QUADRANTS];

   // output register
   logic               rsp_valid_ff,     rsp_valid_in;
   logic               deep_deep_ff,     deep_deep_in;
   logic               deep_shallow_ff,  deep_shallow_in;
   logic [COUNT_W-1:0] deep_count_ff,    deep_count_in;
   logic [COUNT_W-1:0] shallow_count_ff, shallow_count_in;

   logic                 stage_eval;
   logic                 stage_advance;
   logic                 eval_fire;
   logic                 req_fire;
   logic                 csr_fire;
   logic [QUADRANTS-1:0] hit_quads;
   logic                 plane_ok;
   logic [COUNT_W-1:0]   ndeep;
   logic [COUNT_W-1:0]   nshallow;

   // ---------------------------------------------------------------- handshakes
   assign stage_eval    = stage_item_ff.command == CMD_EVAL;
   // A hit always leaves; an end-of-event item needs room in the output register.
   assign stage_advance = stage_valid_ff && (!stage_eval || !rsp_valid_ff || rsp_ch.ready);
   assign eval_fire     = stage_advance && stage_eval;
   assign req_ch.ready  = !stage_valid_ff || stage_advance;
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;
   assign csr_fire      = csr_ch.valid && csr_ch.ready;

   // ---------------------------------------------------------------- register writes
   always_comb begin
      deep_mask_in      = deep_mask_ff;
      shallow_mask_in   = shallow_mask_ff;
      deep_thresh_in    = deep_thresh_ff;
      shallow_thresh_in = shallow_thresh_ff;
      deep_pair_in      = deep_pair_ff;
      if (csr_fire) begin
         case (csr_ch.index)
            REG_DEEP_MASK:      deep_mask_in      = csr_ch.data;
            REG_SHALLOW_MASK:   shallow_mask_in   = csr_ch.data;
            REG_DEEP_THRESH:    deep_thresh_in    = csr_ch.data[THRESH_W-1:0];
            REG_SHALLOW_THRESH: shallow_thresh_in = csr_ch.data[THRESH_W-1:0];
            REG_DEEP_PAIR:      deep_pair_in      = csr_ch.data[PAIR_W-1:0];
            default: ; // drop writes outside the register list
         endcase
      end
   end

   // ---------------------------------------------------------------- input register
   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_item_in  = stage_item_ff;
      if (stage_advance) begin
         stage_valid_in = 1'b0;
      end
      if (req_fire) begin
         stage_valid_in        = 1'b1;
         stage_item_in.command = req_ch.command;
         stage_item_in.panel   = req_ch.panel;
         stage_item_in.plane   = req_ch.plane;
      end
   end

   // ---------------------------------------------------------------- hit update
   assign hit_quads = panel_quadrants(stage_item_ff.panel);
   assign plane_ok  = {1'b0, stage_item_ff.plane} < PLANE_LIMIT;

   always_comb begin
      for (int q = 0; q < QUADRANTS; q++) begin
         store_in[q] = store_ff[q];
         if (stage_advance) begin
            if (stage_eval) begin
               store_in[q] = '0; // clear for the next event
            end else if (plane_ok && hit_quads[q]) begin
               for (int j = 0; j < PLANES; j++) begin
                  if (stage_item_ff.plane == PLANE_W'(j)) begin
                     store_in[q][j] = 1'b1;
                  end
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- evaluation
   // Per quadrant: masked popcount of planes 0..7 against each threshold.
   always_comb begin
      logic [EXT_W-1:0] ext;
      ndeep    = '0;
      nshallow = '0;
      for (int q = 0; q < QUADRANTS; q++) begin
         ext = EXT_W'(store_ff[q]);
         if (count_ones(ext[MASK_W-1:0] & deep_mask_ff) >= deep_thresh_ff) begin
            ndeep = ndeep + COUNT_W'(1);
         end
         if (count_ones(ext[MASK_W-1:0] & shallow_mask_ff) >= shallow_thresh_ff) begin
            nshallow = nshallow + COUNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      deep_deep_in     = deep_deep_ff;
      deep_shallow_in  = deep_shallow_ff;
      deep_count_in    = deep_count_ff;
      shallow_count_in = shallow_count_ff;
      if (eval_fire) begin
         rsp_valid_in     = 1'b1;
         deep_deep_in     = ndeep >= deep_pair_ff;
         deep_shallow_in  = (ndeep != '0) && (nshallow != '0);
         deep_count_in    = ndeep;
         shallow_count_in = nshallow;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.deep_deep     = deep_deep_ff;
   assign rsp_ch.deep_shallow  = deep_shallow_ff;
   assign rsp_ch.deep_count    = deep_count_ff;
   assign rsp_ch.shallow_count = shallow_count_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         deep_mask_ff      <= DEEP_MASK_RST;
         shallow_mask_ff   <= SHALLOW_MASK_RST;
         deep_thresh_ff    <= DEEP_THRESH_RST;
         shallow_thresh_ff <= SHALLOW_THRESH_RST;
         deep_pair_ff      <= DEEP_PAIR_RST;
         stage_valid_ff    <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         for (int q = 0; q < QUADRANTS; q++) begin
            store_ff[q] <= '0;
         end
      end else begin
         deep_mask_ff      <= deep_mask_in;
         shallow_mask_ff   <= shallow_mask_in;
         deep_thresh_ff    <= deep_thresh_in;
         shallow_thresh_ff <= shallow_thresh_in;
         deep_pair_ff      <= deep_pair_in;
         stage_valid_ff    <= stage_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         for (int q = 0; q < QUADRANTS; q++) begin
            store_ff[q] <= store_in[q];
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      stage_item_ff    <= stage_item_in;
      deep_deep_ff     <= deep_deep_in;
      deep_shallow_ff  <= deep_shallow_in;
      deep_count_ff    <= deep_count_in;
      shallow_count_ff <= shallow_count_in;
   end

   // ---------------------------------------------------------------- assertions
   `QPMT_ASSERT_CLK(a_eval_gives_rsp, clock, reset, eval_fire |=> rsp_valid_ff,
                    "end of event lost its result")
   `QPMT_ASSERT_CLK(a_eval_clears, clock, reset,
                    eval_fire |=> (store_ff[0] == '0 && store_ff[1] == '0 &&
                                   store_ff[2] == '0 && store_ff[3] == '0),
                    "store not cleared after evaluation")
   `QPMT_ASSERT_CLK(a_stall_holds, clock, reset,
                    (stage_valid_ff && !stage_advance) |=>
                       (stage_valid_ff && $stable(stage_item_ff)),
                    "stalled item changed")
   `QPMT_ASSERT_NEVER(a_ds_counts, clock, reset,
                      rsp_valid_ff && deep_shallow_ff &&
                         (deep_count_ff == '0 || shallow_count_ff == '0),
                      "deep_shallow without both counts")

endmodule
